/* src/assert_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk with rst_n as disable.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* src/tdm_pkg.sv */
// ---------------------------------------------------------------------------
// tdm_pkg
// Types and orientation functions shared by the tile deduplication chain.
// ---------------------------------------------------------------------------
`default_nettype none

package tdm_pkg;

    localparam int TILE_W = 64;
    localparam int ATTR_W = 8;
    localparam int SLOT_W = 8;
    localparam int UCNT_W = 9;

    typedef logic [TILE_W-1:0] tile_t;
    typedef logic [ATTR_W-1:0] attr_t;

    typedef struct packed {
        logic valid;
        logic found;
    } tdm_ctl_t;

    function automatic tile_t rows_rev(input tile_t t);
        tile_t r;
        for (int k = 0; k < 8; k++)
        begin
            r[8*(7-k) +: 8] = t[8*k +: 8];
        end
        return r;
    endfunction

    function automatic tile_t bits_rev(input tile_t t);
        tile_t r;
        for (int k = 0; k < 8; k++)
        begin
            for (int j = 0; j < 8; j++)
            begin
                r[8*k + j] = t[8*k + 7 - j];
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

/* src/tile_dedup_with_mirroring.sv */
// ---------------------------------------------------------------------------
// tile_dedup_with_mirroring
// Tile deduplication with flip matching over a chain of table cells.
// ---------------------------------------------------------------------------
// A tile is taken when start is high and busy is low. It travels down a chain
// of MAX_TILES cells, one cell per cycle, each cell holding one table entry;
// the first occupied cell whose entry matches under any flip marks the query.
// The result appears on the result ports with done high for exactly one
// cycle, registered after the query leaves the last cell; done is not held
// and the receiver cannot stall it. busy stays high until that cycle, so a
// new tile is taken only after the previous one has left the cell chain. A new
// entry is written at the same edge the result is registered, so the next
// tile already sees it.
// ---------------------------------------------------------------------------
`default_nettype none

module tile_dedup_with_mirroring
    import tdm_pkg::*;
#(
    parameter int MAX_TILES = 256
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    output logic                      busy,
    input  wire logic [TILE_W-1:0]    tile_rows,
    input  wire logic [ATTR_W-1:0]    attribute,
    output logic                      done,
    output logic                      is_new,
    output logic [SLOT_W-1:0]         slot,
    output logic                      table_full,
    output logic [UCNT_W-1:0]         unique_count
);

`include "assert_macros.svh"

    localparam int IDX_W = $clog2(MAX_TILES);
    localparam int CNT_W = $clog2(MAX_TILES+1);

    tdm_ctl_t               ctl_w   [0:MAX_TILES];
    logic [IDX_W-1:0]       slot_w  [0:MAX_TILES];
    tile_t                  tile_w  [0:MAX_TILES];
    attr_t                  attr_w  [0:MAX_TILES];
    logic [MAX_TILES-1:0]   token_vec;

    logic                   accept;
    logic                   busy_reg, busy_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic                   done_reg;
    logic                   is_new_reg, is_new_next;
    logic [SLOT_W-1:0]      slot_reg, slot_next;
    logic                   full_reg, full_next;
    logic [UCNT_W-1:0]      ucnt_reg;
    logic                   room;
    logic                   wr_en;
    logic [IDX_W-1:0]       wr_idx;
    tdm_ctl_t               tail;

    assign accept = start && !busy_reg;

    assign ctl_w[0]  = '{valid: accept, found: 1'b0};
    assign slot_w[0] = '0;
    assign tile_w[0] = tile_rows;
    assign attr_w[0] = attribute;

    for (genvar i = 0; i < MAX_TILES; i++)
    begin : g_cell
        tdm_cell #(
            .MAX_TILES (MAX_TILES),
            .INDEX     (i)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .count    (count_reg),
            .wr_en    (wr_en),
            .wr_idx   (wr_idx),
            .wr_tile  (tile_w[MAX_TILES]),
            .wr_attr  (attr_w[MAX_TILES]),
            .ctl_in   (ctl_w[i]),
            .slot_in  (slot_w[i]),
            .tile_in  (tile_w[i]),
            .attr_in  (attr_w[i]),
            .ctl_out  (ctl_w[i+1]),
            .slot_out (slot_w[i+1]),
            .tile_out (tile_w[i+1]),
            .attr_out (attr_w[i+1])
        );
        assign token_vec[i] = ctl_w[i+1].valid;
    end

    assign tail   = ctl_w[MAX_TILES];
    assign room   = count_reg < CNT_W'(MAX_TILES);
    assign wr_en  = tail.valid && !tail.found && room;
    assign wr_idx = count_reg[IDX_W-1:0];

    always_comb
    begin
        busy_next = busy_reg;
        if (accept)
        begin
            busy_next = 1'b1;
        end
        else if (tail.valid)
        begin
            busy_next = 1'b0;
        end
    end

    always_comb
    begin
        count_next  = count_reg;
        is_new_next = 1'b0;
        full_next   = 1'b0;
        slot_next   = SLOT_W'(slot_w[MAX_TILES]);
        if (!tail.found)
        begin
            if (room)
            begin
                count_next  = count_reg + CNT_W'(1);
                is_new_next = 1'b1;
                slot_next   = SLOT_W'(count_reg);
            end
            else
            begin
                full_next = 1'b1;
                slot_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= tail.valid;
            if (tail.valid)
            begin
                count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (tail.valid)
        begin
            is_new_reg <= is_new_next;
            slot_reg   <= slot_next;
            full_reg   <= full_next;
            ucnt_reg   <= UCNT_W'(count_next);
        end
    end

    assign busy         = busy_reg;
    assign done         = done_reg;
    assign is_new       = is_new_reg;
    assign slot         = slot_reg;
    assign table_full   = full_reg;
    assign unique_count = ucnt_reg;

    `ASSERT_SAME(a_one_token, 1'b1, $onehot0(token_vec))
    `ASSERT_SAME(a_done_idle, done_reg, !busy_reg)
    `ASSERT_NEXT(a_take_busy, start && !busy_reg, busy_reg)
    `ASSERT_SAME(a_excl_flags, done_reg, !(is_new_reg && full_reg))
    `ASSERT_SAME(a_count_bound, 1'b1, count_reg <= CNT_W'(MAX_TILES))

endmodule

`default_nettype wire

/* src/tdm_cell.sv */
// ---------------------------------------------------------------------------
// tdm_cell
// One table entry: holds a stored tile and attribute, checks the passing
// query against it under all four orientations and hands the query on.
// ---------------------------------------------------------------------------
`default_nettype none

module tdm_cell
    import tdm_pkg::*;
#(
    parameter int MAX_TILES = 256,
    parameter int INDEX     = 0
)
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic [$clog2(MAX_TILES+1)-1:0] count,
    input  wire logic                           wr_en,
    input  wire logic [$clog2(MAX_TILES)-1:0]   wr_idx,
    input  wire tile_t                          wr_tile,
    input  wire attr_t                          wr_attr,
    input  wire tdm_ctl_t                       ctl_in,
    input  wire logic [$clog2(MAX_TILES)-1:0]   slot_in,
    input  wire tile_t                          tile_in,
    input  wire attr_t                          attr_in,
    output tdm_ctl_t                            ctl_out,
    output logic [$clog2(MAX_TILES)-1:0]        slot_out,
    output tile_t                               tile_out,
    output attr_t                               attr_out
);

    localparam int IDX_W = $clog2(MAX_TILES);
    localparam int CNT_W = $clog2(MAX_TILES+1);

    tile_t                  store_tile_reg;
    attr_t                  store_attr_reg;
    tdm_ctl_t               ctl_reg, ctl_next;
    logic [IDX_W-1:0]       slot_reg, slot_next;
    tile_t                  tile_reg;
    attr_t                  attr_reg;
    tile_t                  rr;
    logic                   occupied;
    logic                   shape_eq;
    logic                   hit;

    assign rr       = rows_rev(tile_in);
    assign occupied = CNT_W'(INDEX) < count;
    assign shape_eq = (store_tile_reg == tile_in) || (store_tile_reg == rr) ||
                      (store_tile_reg == bits_rev(tile_in)) ||
                      (store_tile_reg == bits_rev(rr));
    assign hit      = ctl_in.valid && !ctl_in.found && occupied &&
                      (store_attr_reg == attr_in) && shape_eq;

    always_comb
    begin
        ctl_next.valid = ctl_in.valid;
        ctl_next.found = ctl_in.found || hit;
        slot_next      = hit ? IDX_W'(INDEX) : slot_in;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else
        begin
            ctl_reg <= ctl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        slot_reg <= slot_next;
        tile_reg <= tile_in;
        attr_reg <= attr_in;
        if (wr_en && (wr_idx == IDX_W'(INDEX)))
        begin
            store_tile_reg <= wr_tile;
            store_attr_reg <= wr_attr;
        end
    end

    assign ctl_out  = ctl_reg;
    assign slot_out = slot_reg;
    assign tile_out = tile_reg;
    assign attr_out = attr_reg;

endmodule

`default_nettype wire
